// ===== design/recc_pkg.sv =====
// Package for the rotary encoder click counter.
// Holds widths, sizes and codes shared by the RAM user, the divider and the core.
// No dependencies.
`default_nettype none

package recc_pkg;

    // Encoder table size and its address width
    localparam int NUM_ENCODERS = 16;
    localparam int ENC_AW       = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    // Field widths
    localparam int INDEX_W   = 4;
    localparam int READING_W = 8;
    localparam int PPC_W     = 8;
    localparam int COUNT_W   = 8;
    localparam int LEFT_W    = 9;   // signed leftover, |value| < 256
    localparam int DELTA_W   = 9;   // wrapped difference, -128..128
    localparam int SUM_W     = 10;  // delta plus leftover, -382..382
    localparam int MAG_W     = 9;   // magnitude of the sum, 0..382

    // One table row: previous reading above signed leftover
    localparam int ROW_W = READING_W + LEFT_W;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Constants
    localparam logic [PPC_W-1:0]   PPC_RESET = PPC_W'(1);
    localparam logic [PPC_W-1:0]   PPC_MIN   = PPC_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Direction codes
    localparam logic DIR_INC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

endpackage

`default_nettype wire

// ===== design/recc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`default_nettype none

module recc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/recc_div.sv =====
// Restoring divider for the click counter: magnitude by pulses per click.
// One quotient bit per cycle. Depends on recc_pkg.
`default_nettype none

module recc_div import recc_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MAG_W-1:0]   dividend,
    input  wire logic [PPC_W-1:0]   divisor,
    output logic                    done,
    output logic      [MAG_W-1:0]   quotient,
    output logic      [PPC_W-1:0]   remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [PPC_W-1:0]  rem_reg;
    logic [PPC_W-1:0]  dsr_reg;

    logic [PPC_W:0]    trial;
    logic [PPC_W-1:0]  trial_diff;
    logic              trial_ge;
    logic [PPC_W-1:0]  rem_next;

    // Shift in next dividend bit, try to subtract the divisor
    always_comb
    begin
        trial      = {rem_reg, quo_reg[MAG_W-1]};
        trial_ge   = (trial >= {1'b0, dsr_reg});
        trial_diff = trial[PPC_W-1:0] - dsr_reg;   // fits when trial_ge
        rem_next   = trial_ge ? trial_diff : trial[PPC_W-1:0];
    end

    // Iteration control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                quo_reg  <= {quo_reg[MAG_W-2:0], trial_ge};
                rem_reg  <= rem_next;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== design/rotary_encoder_click_counter_core.sv =====
// Rotary encoder click counter core.
// Per-encoder table in recc_ram, iterative division in recc_div. Depends on recc_pkg.
// Usage:
//   Input channel (in_valid/in_ready): one beat carries encoder_index and the
//   encoder's new 8-bit counter_reading. Every beat yields exactly one result beat.
//   Output channel (out_valid/out_ready): click_direction (0 up, 1 down) and
//   click_count (whole detent clicks, saturating at 255).
//   Config channel (cfg_valid/cfg_ready): cfg_data sets pulses_per_click, shared
//   by all encoders; 0 acts as 1. cfg_ready is always high; write only while idle.
// Timing:
//   One item at a time. A reading that moves the encoder goes from acceptance
//   through the decode, divide and done states, the divide set by the 9-step
//   restoring divider; an unchanged reading or an index out of range skips divide.
//   The row is read in the accept cycle, written back once at the end after a divide.
// Reset:
//   Asynchronous, active low. pulses_per_click returns to 1; per-entry valid
//   flags make every encoder read as previous reading 0, leftover 0 at once.
// Stall:
//   The result sits in an output register; the next beat is accepted while it
//   waits. A following result waits in its final state until the register frees.
`default_nettype none

module rotary_encoder_click_counter_core import recc_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [INDEX_W-1:0]    encoder_index,
    input  wire logic [READING_W-1:0]  counter_reading,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       click_direction,
    output logic      [COUNT_W-1:0]    click_count,
    // config channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [PPC_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [PPC_W-1:0]        ppc_reg;
    logic [NUM_ENCODERS-1:0] row_valid_reg;

    // Item context
    logic [ENC_AW-1:0]       idx_reg;
    logic [READING_W-1:0]    reading_reg;
    logic                    in_range_reg;
    logic                    neg_reg;
    logic                    write_reg;
    logic [LEFT_W-1:0]       left_reg;
    logic                    res_dir_reg;
    logic [COUNT_W-1:0]      res_cnt_reg;

    // Output register
    logic                    out_valid_reg;
    logic                    out_dir_reg;
    logic [COUNT_W-1:0]      out_cnt_reg;

    // Table RAM ports
    logic                    ram_we;
    logic                    ram_re;
    logic [ROW_W-1:0]        ram_rdata;

    // Divider ports
    logic                    div_start;
    logic                    div_done;
    logic [MAG_W-1:0]        div_quo;
    logic [PPC_W-1:0]        div_rem;

    // Row decode and arithmetic
    logic                    in_beat;
    logic                    out_free;
    logic                    row_valid;
    logic [READING_W-1:0]    prev_rd;
    logic [LEFT_W-1:0]       left_rd;
    logic [READING_W-1:0]    diff8;
    logic [DELTA_W-1:0]      delta;
    logic [SUM_W-1:0]        sum;
    logic [MAG_W-1:0]        mag;
    logic [PPC_W-1:0]        ppc_eff;
    logic [LEFT_W-1:0]       left_next;
    logic [COUNT_W-1:0]      cnt_next;
    logic                    dir_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Table row: previous reading and signed leftover; unwritten rows read as zero
    assign row_valid = row_valid_reg[idx_reg];
    assign prev_rd   = row_valid ? ram_rdata[ROW_W-1 -: READING_W] : '0;
    assign left_rd   = row_valid ? ram_rdata[LEFT_W-1:0] : '0;

    // Wrapped difference; a half-turn difference takes its sign from a compare of the two readings
    always_comb
    begin
        diff8 = reading_reg - prev_rd;
        if (diff8 == {1'b1, {(READING_W-1){1'b0}}})
        begin
            delta = (reading_reg > prev_rd) ? DELTA_W'(-128) : DELTA_W'(128);
        end
        else
        begin
            delta = {diff8[READING_W-1], diff8};
        end
        sum     = {delta[DELTA_W-1], delta} + {left_rd[LEFT_W-1], left_rd};
        mag     = sum[SUM_W-1] ? MAG_W'(SUM_W'(0) - sum) : sum[MAG_W-1:0];
        ppc_eff = (ppc_reg == '0) ? PPC_MIN : ppc_reg;
    end

    // Division result to clicks and new leftover
    always_comb
    begin
        left_next = neg_reg ? (LEFT_W'(0) - {1'b0, div_rem}) : {1'b0, div_rem};
        cnt_next  = (div_quo[MAG_W-1:COUNT_W] != '0) ? COUNT_MAX : div_quo[COUNT_W-1:0];
        dir_next  = (neg_reg && (div_quo != '0)) ? DIR_DEC : DIR_INC;
    end

    assign div_start = (state_reg == S_CALC) && in_range_reg && (diff8 != '0);
    assign ram_re    = in_beat;
    assign ram_we    = (state_reg == S_DONE) && out_free && write_reg;

    recc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ENCODERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata ({reading_reg, left_reg}),
        .re    (ram_re),
        .raddr (ENC_AW'(encoder_index)),
        .rdata (ram_rdata)
    );

    recc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag),
        .divisor   (ppc_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer, config register, row flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ppc_reg       <= PPC_RESET;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            write_reg     <= 1'b0;
            idx_reg       <= '0;
            reading_reg   <= '0;
            in_range_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            left_reg      <= '0;
            res_dir_reg   <= DIR_INC;
            res_cnt_reg   <= '0;
            out_dir_reg   <= DIR_INC;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ppc_reg <= cfg_data;
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        idx_reg      <= ENC_AW'(encoder_index);
                        reading_reg  <= counter_reading;
                        in_range_reg <= (32'(encoder_index) < NUM_ENCODERS);
                        state_reg    <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    neg_reg <= sum[SUM_W-1];
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        // no motion or unknown encoder: zero result, table untouched
                        res_dir_reg <= DIR_INC;
                        res_cnt_reg <= '0;
                        write_reg   <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_dir_reg <= dir_next;
                        res_cnt_reg <= cnt_next;
                        left_reg    <= left_next;
                        write_reg   <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dir_reg   <= res_dir_reg;
                        out_cnt_reg   <= res_cnt_reg;
                        if (write_reg)
                        begin
                            row_valid_reg[idx_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign click_direction = out_dir_reg;
    assign click_count     = out_cnt_reg;

`ifndef NO_ASSERTIONS
    // A decrement is only reported with at least one click
    a_dir_needs_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && click_direction) |-> (click_count != '0))
        else $error("decrement reported with zero clicks");

    // Divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // Stored leftover magnitude stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_rem < ppc_eff))
        else $error("remainder not below pulses per click");

    // Table write-back only for an in-range encoder at the end of an item
    a_write_scope: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_DONE) && in_range_reg))
        else $error("table written outside write-back");

    // An accepted beat always moves on to the row decode
    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_CALC))
        else $error("accepted beat did not reach decode");
`endif

endmodule

`default_nettype wire
